@@ hw/rtl/pqil_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue inflight limiter package
// Shared constants, operation codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pqil_pkg;

    // Queue organization.
    localparam int RT_LEVELS     = 8;
    localparam int QUEUE_DEPTH   = 16;
    localparam int TAG_WIDTH     = 8;
    localparam int NUM_QUEUES    = RT_LEVELS + 1;
    localparam int BE_QUEUE      = RT_LEVELS;
    localparam int DEFAULT_LEVEL = (4 < RT_LEVELS) ? 4 : RT_LEVELS - 1;

    // Derived widths.
    localparam int QIDX_W    = $clog2(NUM_QUEUES);
    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Fixed field widths of the item ports.
    localparam int OPCODE_W   = 2;
    localparam int REQ_TAG_W  = 8;
    localparam int CLASS_W    = 2;
    localparam int LEVEL_W    = 4;
    localparam int GQUEUE_W   = 4;
    localparam int INFLIGHT_W = 16;

    // Class code for real-time requests.
    localparam logic [CLASS_W-1:0] CLASS_RT = 2'd1;

    // Item operations.
    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

@@ hw/rtl/priority_queue_inflight_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue inflight limiter
// Strict-priority request scheduler with eight real-time queues, one
// best-effort queue and a limit on outstanding dispatched requests.
// ----------------------------------------------------------------------------
// Each item passes through an execute step that updates the queue
// pointers, counts and inflight counter and issues the tag memory access,
// then a load step in which the registered tag read returns and the result
// is loaded into the output register. The next item is taken in the load
// step, so a new item is not accepted while the last one is in its
// execute step. The tag memory read is registered, so its data returns
// in the load step that follows the execute step.
// A stalled result holds the block at the load step. No clearing pass is
// needed after reset. The user must write the in-flight limit only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module priority_queue_inflight_limiter
    import pqil_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration.
    input  logic                  i_cfg_we,
    input  logic [INFLIGHT_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [REQ_TAG_W-1:0]  i_req_tag,
    input  logic [CLASS_W-1:0]    i_prio_class,
    input  logic [LEVEL_W-1:0]    i_prio_level,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_accepted,
    output logic                  o_granted,
    output logic [REQ_TAG_W-1:0]  o_grant_tag,
    output logic [GQUEUE_W-1:0]   o_grant_queue,
    output logic [INFLIGHT_W-1:0] o_inflight_now,
    output logic                  o_work_pending,
    output logic                  o_rerun_hint
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller.
    pqil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    pqil_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_req_tag      (i_req_tag),
        .i_prio_class   (i_prio_class),
        .i_prio_level   (i_prio_level),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_accepted     (o_accepted),
        .o_granted      (o_granted),
        .o_grant_tag    (o_grant_tag),
        .o_grant_queue  (o_grant_queue),
        .o_inflight_now (o_inflight_now),
        .o_work_pending (o_work_pending),
        .o_rerun_hint   (o_rerun_hint)
    );

    // An accepted item is followed by input stall in the next cycle.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input item accepted in two consecutive cycles");

    // Loading a result always presents it on the next cycle.
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out_valid)
        else $error("loaded result not presented");

    // One result never reports both an insert and a grant, nor a hint with them.
    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_granted) &&
                        !(o_rerun_hint && (o_accepted || o_granted)))
        else $error("result flags of different operations both set");

    // A granted dispatch leaves at least one request in flight.
    a_grant_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |-> (o_inflight_now != '0))
        else $error("grant reported with zero inflight count");

endmodule

@@ hw/rtl/pqil_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pqil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pqil_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue inflight limiter controller
// Sequences each item through capture, execute and result load, and drives
// the input stall.
// ----------------------------------------------------------------------------
module pqil_ctrl
    import pqil_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   take;

    // An item is taken when idle, or when the previous result is leaving.
    assign take = (r_state == ST_IDLE) || ((r_state == ST_LOAD) && i_sts.out_free);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    n_state = i_in_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_stall    = !take;
        o_cmd.capture = take && i_in_valid;
        o_cmd.exec    = (r_state == ST_EXEC);
        o_cmd.emit    = (r_state == ST_LOAD) && i_sts.out_free;
    end

endmodule

@@ hw/rtl/pqil_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue inflight limiter datapath
// Holds the queue pointers and counts, the inflight counter, the limit
// register, the tag memory and the result register.
// ----------------------------------------------------------------------------
module pqil_dp
    import pqil_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    // Configuration.
    input  logic                  i_cfg_we,
    input  logic [INFLIGHT_W-1:0] i_cfg_data,
    // Input item fields.
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [REQ_TAG_W-1:0]  i_req_tag,
    input  logic [CLASS_W-1:0]    i_prio_class,
    input  logic [LEVEL_W-1:0]    i_prio_level,
    // Result channel.
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_accepted,
    output logic                  o_granted,
    output logic [REQ_TAG_W-1:0]  o_grant_tag,
    output logic [GQUEUE_W-1:0]   o_grant_queue,
    output logic [INFLIGHT_W-1:0] o_inflight_now,
    output logic                  o_work_pending,
    output logic                  o_rerun_hint
);

    // Captured item.
    t_opcode              r_op;
    logic [REQ_TAG_W-1:0] r_req_tag;
    logic [CLASS_W-1:0]   r_prio_class;
    logic [LEVEL_W-1:0]   r_prio_level;

    // Queue bookkeeping and counters.
    logic [SLOT_W-1:0]     r_head [NUM_QUEUES];
    logic [SLOT_W-1:0]     r_tail [NUM_QUEUES];
    logic [CNT_W-1:0]      r_cnt  [NUM_QUEUES];
    logic [INFLIGHT_W-1:0] r_inflight;
    logic [INFLIGHT_W-1:0] r_max;

    // Per-item results held until the tag read returns.
    logic              r_res_accepted;
    logic              r_res_granted;
    logic [QIDX_W-1:0] r_res_queue;
    logic              r_res_rerun;

    // Result register.
    logic                  r_out_valid;
    logic                  r_accepted;
    logic                  r_granted;
    logic [REQ_TAG_W-1:0]  r_grant_tag;
    logic [GQUEUE_W-1:0]   r_grant_queue;
    logic [INFLIGHT_W-1:0] r_inflight_now;
    logic                  r_work_pending;
    logic                  r_rerun_hint;

    // Execute-stage decisions.
    logic [QIDX_W-1:0]     ins_q;
    logic                  ins_ok;
    logic [QIDX_W-1:0]     disp_q;
    logic                  disp_found;
    logic                  disp_ok;
    logic [INFLIGHT_W-1:0] inflight_dec;
    logic                  rerun;
    logic                  any_queued;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [TAG_WIDTH-1:0]  wtag;
    logic [TAG_WIDTH-1:0]  rtag;

    // Capture the item fields at acceptance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= t_opcode'(i_opcode);
            r_req_tag    <= i_req_tag;
            r_prio_class <= i_prio_class;
            r_prio_level <= i_prio_level;
        end
    end

    // Target queue of an insert: out-of-range levels fold to the default level.
    always_comb begin
        if (r_prio_class != CLASS_RT) begin
            ins_q = QIDX_W'(BE_QUEUE);
        end else if ({1'b0, r_prio_level} >= (LEVEL_W + 1)'(RT_LEVELS)) begin
            ins_q = QIDX_W'(DEFAULT_LEVEL);
        end else begin
            ins_q = QIDX_W'(r_prio_level);
        end
        ins_ok = (r_cnt[ins_q] < CNT_W'(QUEUE_DEPTH));
    end

    // Lowest-numbered non-empty queue.
    always_comb begin
        disp_q     = '0;
        disp_found = 1'b0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
            if (r_cnt[q] != '0) begin
                disp_q     = QIDX_W'(q);
                disp_found = 1'b1;
            end
        end
        disp_ok = disp_found && (r_inflight < r_max);
    end

    // Completion: decrement stopping at zero, hint when one slot opens.
    always_comb begin
        inflight_dec = (r_inflight != '0) ? r_inflight - INFLIGHT_W'(1) : r_inflight;
        rerun = ({1'b0, inflight_dec} + (INFLIGHT_W + 1)'(1)) == {1'b0, r_max};
    end

    // Tag memory addressing.
    assign wtag  = TAG_WIDTH'(r_req_tag);
    assign waddr = ADDR_W'(ins_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_tail[ins_q]);
    assign raddr = ADDR_W'(disp_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_head[disp_q]);

    pqil_ram #(
        .WIDTH (TAG_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && (r_op == OP_INSERT) && ins_ok),
        .i_waddr (waddr),
        .i_wdata (wtag),
        .i_re    (i_cmd.exec && (r_op == OP_DISPATCH) && disp_ok),
        .i_raddr (raddr),
        .o_rdata (rtag)
    );

    // Queue pointers, counts and the inflight counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_cnt[q]  <= '0;
            end
            r_inflight <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_INSERT: begin
                    if (ins_ok) begin
                        r_tail[ins_q] <= (r_tail[ins_q] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : r_tail[ins_q] + SLOT_W'(1);
                        r_cnt[ins_q]  <= r_cnt[ins_q] + CNT_W'(1);
                    end
                end
                OP_DISPATCH: begin
                    if (disp_ok) begin
                        r_head[disp_q] <= (r_head[disp_q] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                          '0 : r_head[disp_q] + SLOT_W'(1);
                        r_cnt[disp_q]  <= r_cnt[disp_q] - CNT_W'(1);
                        if (r_inflight != '1) begin
                            r_inflight <= r_inflight + INFLIGHT_W'(1);
                        end
                    end
                end
                OP_COMPLETE: begin
                    r_inflight <= inflight_dec;
                end
                default: begin
                end
            endcase
        end
    end

    // Per-item result flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_accepted <= (r_op == OP_INSERT) && ins_ok;
            r_res_granted  <= (r_op == OP_DISPATCH) && disp_ok;
            r_res_queue    <= ((r_op == OP_DISPATCH) && disp_ok) ? disp_q : '0;
            r_res_rerun    <= (r_op == OP_COMPLETE) && rerun;
        end
    end

    // Limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= INFLIGHT_W'(1);
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    // Work remains when something is queued and the limit is not reached.
    always_comb begin
        any_queued = 1'b0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            any_queued = any_queued | (r_cnt[q] != '0);
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_accepted     <= r_res_accepted;
            r_granted      <= r_res_granted;
            r_grant_tag    <= r_res_granted ? REQ_TAG_W'(rtag) : '0;
            r_grant_queue  <= GQUEUE_W'(r_res_queue);
            r_inflight_now <= r_inflight;
            r_work_pending <= any_queued && (r_inflight < r_max);
            r_rerun_hint   <= r_res_rerun;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_granted      = r_granted;
    assign o_grant_tag    = r_grant_tag;
    assign o_grant_queue  = r_grant_queue;
    assign o_inflight_now = r_inflight_now;
    assign o_work_pending = r_work_pending;
    assign o_rerun_hint   = r_rerun_hint;

endmodule
